@@ rtl/core/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int COL_W    = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W    = $clog2(SCREEN_ROWS);
  localparam int ADDR_W   = $clog2(CELL_COUNT);
  localparam int INDEX_W  = 11;
  localparam int CODE_W   = 8;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int TAB_W    = 4;
  localparam int PCOL_W   = 7;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CMP_W    = (COL_W > PCOL_W) ? COL_W : PCOL_W;
  localparam int COLSUM_W = ((COL_W > TAB_W) ? COL_W : TAB_W) + 1;
  localparam int WIDE_W   = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [INDEX_W-1:0]    index_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [ATTR_W-1:0]     attr_t;
  typedef logic [TAB_W-1:0]      tab_t;
  typedef logic [PCOL_W-1:0]     pcol_t;
  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [COLSUM_W-1:0]   colsum_t;
  typedef logic [WIDE_W-1:0]     wide_t;

  localparam cmd_t CMD_PUT   = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  localparam cfg_idx_t CFG_ATTRIBUTE = 2'd0;
  localparam cfg_idx_t CFG_TAB       = 2'd1;
  localparam cfg_idx_t CFG_PROT_COL  = 2'd2;

  localparam attr_t ATTR_RESET     = 8'h07;
  localparam tab_t  TAB_RESET      = 4'd4;
  localparam pcol_t PROT_COL_RESET = 7'd3;

  localparam code_t CH_BS        = 8'h08;
  localparam code_t CH_TAB       = 8'h09;
  localparam code_t CH_LF        = 8'h0A;
  localparam code_t CH_CR        = 8'h0D;
  localparam code_t CH_SPACE     = 8'h20;
  localparam code_t CH_PRINT_END = 8'h80;

  localparam cell_t BLANK_CELL = 16'h0720;

  typedef struct packed {
    attr_t attr;
    tab_t  tab;
    pcol_t pcol;
  } cfg_t;

  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    cell_t wdata;
  } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_screen_ram.sv @@
`default_nettype none

module tcw_screen_ram (
  input  wire logic             clk,
  input  wire tcw_pkg::ram_req_t req,
  output tcw_pkg::cell_t        rd_data
);

  tcw_pkg::cell_t mem_r [tcw_pkg::CELL_COUNT];
  tcw_pkg::cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire tcw_pkg::cmd_t     command,
  input  wire tcw_pkg::code_t    char_code,
  input  wire tcw_pkg::index_t   cell_index,
  input  wire tcw_pkg::cfg_t     cfg,
  output logic                   busy,
  output tcw_pkg::ram_req_t      ram_req,
  input  wire tcw_pkg::cell_t    ram_rdata,
  output logic                   out_valid,
  output tcw_pkg::index_t        out_cursor_location,
  output tcw_pkg::cell_t         out_cell_data,
  output logic                   out_scrolled
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PHYS,
    S_BASE,
    S_FILL,
    S_WRITE,
    S_RD,
    S_RDWAIT,
    S_APPLY,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;
  logic   out_scrolled_r;
  tcw_pkg::index_t out_loc_r;
  tcw_pkg::cell_t  out_data_r;

  tcw_pkg::col_t  col_r;
  tcw_pkg::row_t  row_r;
  tcw_pkg::row_t  top_r;
  logic [tcw_pkg::SCREEN_ROWS-1:0] valid_r;

  logic           is_read_r;
  tcw_pkg::col_t  tcol_r;
  tcw_pkg::row_t  trow_r;
  tcw_pkg::cell_t wdata_r;
  tcw_pkg::col_t  dcol_r;
  tcw_pkg::row_t  drow_r;
  logic           scroll_r;
  tcw_pkg::wide_t rem_r;
  tcw_pkg::row_t  p_r;
  tcw_pkg::addr_t base_r;
  tcw_pkg::col_t  k_r;
  tcw_pkg::cell_t data_r;

  logic           wr_nxt;
  tcw_pkg::col_t  tcol_nxt;
  tcw_pkg::cell_t wdata_nxt;
  tcw_pkg::col_t  dcol_nxt;
  tcw_pkg::row_t  drow_nxt;
  logic           scroll_nxt;
  logic           wrap;
  logic           last_row;
  tcw_pkg::col_t  bs_col;
  tcw_pkg::col_t  bs_next;
  tcw_pkg::colsum_t tab_sum;
  logic           printable;

  tcw_pkg::wide_t alu_a;
  tcw_pkg::wide_t alu_b;
  tcw_pkg::wide_t alu_diff;
  logic           alu_ge;

  tcw_pkg::addr_t loc;

  function automatic tcw_pkg::col_t step_back(tcw_pkg::col_t c, tcw_pkg::pcol_t pc);
    logic hit;
    hit = (tcw_pkg::cmp_t'(c) == tcw_pkg::cmp_t'(pc));
    if (c != '0 && !hit) begin
      return c - tcw_pkg::col_t'(1);
    end
    return c;
  endfunction

  // cursor motion for a put transaction
  assign last_row  = (row_r == tcw_pkg::row_t'(tcw_pkg::SCREEN_ROWS - 1));
  assign bs_col    = step_back(col_r, cfg.pcol);
  assign bs_next   = step_back(bs_col + tcw_pkg::col_t'(1), cfg.pcol);
  assign tab_sum   = tcw_pkg::colsum_t'(col_r) + tcw_pkg::colsum_t'(cfg.tab);
  assign printable = (char_code >= tcw_pkg::CH_SPACE) && (char_code < tcw_pkg::CH_PRINT_END);

  always_comb begin
    wr_nxt     = 1'b0;
    tcol_nxt   = col_r;
    wdata_nxt  = {cfg.attr, char_code};
    dcol_nxt   = col_r;
    drow_nxt   = row_r;
    scroll_nxt = 1'b0;
    wrap       = 1'b0;
    case (char_code)
      tcw_pkg::CH_BS: begin
        wr_nxt    = 1'b1;
        tcol_nxt  = bs_col;
        wdata_nxt = {cfg.attr, tcw_pkg::CH_SPACE};
        if (bs_col == tcw_pkg::col_t'(tcw_pkg::SCREEN_COLUMNS - 1)) begin
          dcol_nxt = '0;
          wrap     = 1'b1;
        end else begin
          dcol_nxt = bs_next;
        end
      end
      tcw_pkg::CH_TAB: begin
        if (tab_sum >= tcw_pkg::colsum_t'(tcw_pkg::SCREEN_COLUMNS)) begin
          dcol_nxt = '0;
          wrap     = 1'b1;
        end else begin
          dcol_nxt = tcw_pkg::col_t'(tab_sum);
        end
      end
      tcw_pkg::CH_CR: begin
        dcol_nxt = '0;
      end
      tcw_pkg::CH_LF: begin
        dcol_nxt = '0;
        wrap     = 1'b1;
      end
      default: begin
        if (printable) begin
          wr_nxt = 1'b1;
          if (col_r == tcw_pkg::col_t'(tcw_pkg::SCREEN_COLUMNS - 1)) begin
            dcol_nxt = '0;
            wrap     = 1'b1;
          end else begin
            dcol_nxt = col_r + tcw_pkg::col_t'(1);
          end
        end
      end
    endcase
    if (wrap) begin
      scroll_nxt = last_row;
      drow_nxt   = last_row ? row_r : row_r + tcw_pkg::row_t'(1);
    end
  end

  // shared subtract and compare: row division and ring row wrap
  always_comb begin
    if (state_r == S_DIV) begin
      alu_a = rem_r;
      alu_b = tcw_pkg::wide_t'(tcw_pkg::SCREEN_COLUMNS);
    end else begin
      alu_a = tcw_pkg::wide_t'(top_r) + tcw_pkg::wide_t'(trow_r);
      alu_b = tcw_pkg::wide_t'(tcw_pkg::SCREEN_ROWS);
    end
    alu_ge   = (alu_a >= alu_b);
    alu_diff = alu_a - alu_b;
  end

  always_comb begin
    ram_req.we    = (state_r == S_FILL) || (state_r == S_WRITE);
    ram_req.re    = (state_r == S_RD);
    ram_req.addr  = base_r + tcw_pkg::addr_t'((state_r == S_FILL) ? k_r : tcol_r);
    ram_req.wdata = ((state_r == S_FILL) && (k_r != tcol_r)) ? tcw_pkg::BLANK_CELL : wdata_r;
  end

  assign loc = tcw_pkg::addr_t'(row_r) * tcw_pkg::addr_t'(tcw_pkg::SCREEN_COLUMNS)
             + tcw_pkg::addr_t'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
      valid_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            busy_r    <= 1'b1;
            is_read_r <= 1'b0;
            data_r    <= '0;
            dcol_r    <= col_r;
            drow_r    <= row_r;
            scroll_r  <= 1'b0;
            state_r   <= S_APPLY;
            unique case (command)
              tcw_pkg::CMD_PUT: begin
                tcol_r   <= tcol_nxt;
                trow_r   <= row_r;
                wdata_r  <= wdata_nxt;
                dcol_r   <= dcol_nxt;
                drow_r   <= drow_nxt;
                scroll_r <= scroll_nxt;
                if (wr_nxt) begin
                  state_r <= S_PHYS;
                end
              end
              tcw_pkg::CMD_CLEAR: begin
                valid_r <= '0;
                dcol_r  <= '0;
                drow_r  <= '0;
              end
              tcw_pkg::CMD_READ: begin
                if (tcw_pkg::wide_t'(cell_index) < tcw_pkg::wide_t'(tcw_pkg::CELL_COUNT)) begin
                  is_read_r <= 1'b1;
                  rem_r     <= tcw_pkg::wide_t'(cell_index);
                  trow_r    <= '0;
                  state_r   <= S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (alu_ge) begin
            rem_r  <= alu_diff;
            trow_r <= trow_r + tcw_pkg::row_t'(1);
          end else begin
            tcol_r  <= tcw_pkg::col_t'(rem_r);
            state_r <= S_PHYS;
          end
        end
        S_PHYS: begin
          p_r     <= tcw_pkg::row_t'(alu_ge ? alu_diff : alu_a);
          state_r <= S_BASE;
        end
        S_BASE: begin
          base_r <= tcw_pkg::addr_t'(p_r) * tcw_pkg::addr_t'(tcw_pkg::SCREEN_COLUMNS);
          k_r    <= '0;
          if (is_read_r) begin
            if (valid_r[p_r]) begin
              state_r <= S_RD;
            end else begin
              data_r  <= tcw_pkg::BLANK_CELL;
              state_r <= S_APPLY;
            end
          end else begin
            state_r <= valid_r[p_r] ? S_WRITE : S_FILL;
          end
        end
        S_FILL: begin
          k_r <= k_r + tcw_pkg::col_t'(1);
          if (k_r == tcw_pkg::col_t'(tcw_pkg::SCREEN_COLUMNS - 1)) begin
            valid_r[p_r] <= 1'b1;
            state_r      <= S_APPLY;
          end
        end
        S_WRITE: begin
          state_r <= S_APPLY;
        end
        S_RD: begin
          state_r <= S_RDWAIT;
        end
        S_RDWAIT: begin
          data_r  <= ram_rdata;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          col_r <= dcol_r;
          row_r <= drow_r;
          if (scroll_r) begin
            valid_r[top_r] <= 1'b0;
            top_r <= (top_r == tcw_pkg::row_t'(tcw_pkg::SCREEN_ROWS - 1)) ?
                     '0 : top_r + tcw_pkg::row_t'(1);
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          out_valid_r    <= 1'b1;
          out_loc_r      <= tcw_pkg::index_t'(loc);
          out_data_r     <= data_r;
          out_scrolled_r <= scroll_r;
          busy_r         <= 1'b0;
          state_r        <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                = busy_r;
  assign out_valid           = out_valid_r;
  assign out_cursor_location = out_loc_r;
  assign out_cell_data       = out_data_r;
  assign out_scrolled        = out_scrolled_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r)
    else $error("accepted transaction did not raise busy");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r == S_FINISH) && !busy_r))
    else $error("result strobe without finish");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrolled_r) |-> (row_r == tcw_pkg::row_t'(tcw_pkg::SCREEN_ROWS - 1)))
    else $error("scroll left cursor off the last row");

  a_write_in_valid_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> valid_r[p_r])
    else $error("single cell write into a row that was never filled");
`endif

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer_top.sv @@
`default_nettype none

// control codes, clear, unused commands, reads out of range: apply, finish, strobe;
// printable or backspace: ring row, base, then one cell write or an 80-cell blank row fill
// read: repeated subtract splits the index, then ring row, base, RAM read unless blank
// transactions: one at a time; start is taken again in the strobe cycle
// reset: synchronous, clears cursor, scroll offset and row valid flags, loads config defaults; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle

module text_console_writer_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tcw_pkg::cmd_t        in_command,
  input  wire tcw_pkg::code_t       in_char_code,
  input  wire tcw_pkg::index_t      in_cell_index,
  output logic                      out_valid,
  output tcw_pkg::index_t           out_cursor_location,
  output tcw_pkg::cell_t            out_cell_data,
  output logic                      out_scrolled,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire tcw_pkg::cfg_idx_t    cfg_index,
  input  wire tcw_pkg::cfg_data_t   cfg_data
);

  tcw_pkg::attr_t    attr_r;
  tcw_pkg::tab_t     tab_r;
  tcw_pkg::pcol_t    pcol_r;
  tcw_pkg::cfg_t     cfg;
  tcw_pkg::ram_req_t ram_req;
  tcw_pkg::cell_t    ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
      tab_r  <= tcw_pkg::TAB_RESET;
      pcol_r <= tcw_pkg::PROT_COL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcw_pkg::CFG_ATTRIBUTE: attr_r <= cfg_data;
        tcw_pkg::CFG_TAB:       tab_r  <= cfg_data[tcw_pkg::TAB_W-1:0];
        tcw_pkg::CFG_PROT_COL:  pcol_r <= cfg_data[tcw_pkg::PCOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = {attr_r, tab_r, pcol_r};

  tcw_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .command             (in_command),
    .char_code           (in_char_code),
    .cell_index          (in_cell_index),
    .cfg                 (cfg),
    .busy                (busy),
    .ram_req             (ram_req),
    .ram_rdata           (ram_rdata),
    .out_valid           (out_valid),
    .out_cursor_location (out_cursor_location),
    .out_cell_data       (out_cell_data),
    .out_scrolled        (out_scrolled)
  );

  tcw_screen_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

endmodule

`default_nettype wire
